>>> hdl/shmr_pkg.sv
// Package for the segmented half minimum reduction unit.
// Holds the transaction types, sizing constants and the half compare function.
// No dependencies.
package shmr_pkg;

   localparam int MAX_CHUNKS = 16;
   localparam int LANES      = 4;
   localparam int HALF_W     = 16;
   localparam int CHUNK_AW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int ROW_W      = LANES * HALF_W;

   localparam logic [HALF_W-1:0] HALF_MAX_FINITE = 16'h7BFF;
   localparam logic [HALF_W-1:0] HALF_ZERO       = 16'h0000;

   localparam logic OP_CHUNK = 1'b0;
   localparam logic OP_EMPTY = 1'b1;

   typedef struct packed {
      logic              op;
      logic [3:0]        chunk_index;
      logic              first_neighbor;
      logic              last_neighbor;
      logic [HALF_W-1:0] lane_0;
      logic [HALF_W-1:0] lane_1;
      logic [HALF_W-1:0] lane_2;
      logic [HALF_W-1:0] lane_3;
   } req_type;

   typedef struct packed {
      logic [3:0]        out_chunk;
      logic [HALF_W-1:0] min_0;
      logic [HALF_W-1:0] min_1;
      logic [HALF_W-1:0] min_2;
      logic [HALF_W-1:0] min_3;
   } rsp_type;

   function automatic logic half_is_nan(input logic [HALF_W-1:0] h);
      return (h[14:10] == 5'h1F) && (h[9:0] != 10'h000);
   endfunction

   // Signed ordering key; both zeros map to zero.
   function automatic logic signed [HALF_W:0] half_key(input logic [HALF_W-1:0] h);
      logic signed [HALF_W:0] mag;
      mag = $signed({2'b00, h[14:0]});
      return h[15] ? -mag : mag;
   endfunction

   function automatic logic [HALF_W-1:0] half_min(input logic [HALF_W-1:0] acc,
                                                 input logic [HALF_W-1:0] x);
      if (half_is_nan(x))   return acc;
      if (half_is_nan(acc)) return x;
      return (half_key(x) < half_key(acc)) ? x : acc;
   endfunction

   function automatic logic [HALF_W-1:0] req_lane(input req_type r, input int k);
      logic [HALF_W-1:0] v;
      case (k)
         0:       v = r.lane_0;
         1:       v = r.lane_1;
         2:       v = r.lane_2;
         default: v = r.lane_3;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/segmented_half_min_reduce_unit.sv
// Segmented half minimum reduction unit, top level.
// A request is held in the stage 1 register, then in the output register.
// Throughput: one transaction per cycle unless a full output register stalls stage 1;
//   the accumulator RAM read is issued on accept and the compare lanes write back when stage 1 advances, with bypass.
// Reset: synchronous, active high; clears pipeline valids and the bypass entry.
//   Accumulator RAM contents are undefined until a segment's first neighbor.
module segmented_half_min_reduce_unit
   import shmr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // stage 1: request waiting on RAM read data
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff;
   logic    accept, s1_advance, s1_in_range, s1_wr, s1_emit, out_free;

   // bypass of the most recent write
   logic                fw_valid_ff;
   logic [CHUNK_AW-1:0] fw_addr_ff;
   logic [ROW_W-1:0]    fw_data_ff;

   logic [ROW_W-1:0] ram_rd, acc_row, res_row;
   logic [CHUNK_AW-1:0] s1_addr;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_in_range = 32'(s1_req_ff.chunk_index) < MAX_CHUNKS;
   assign s1_emit     = (s1_req_ff.op == OP_EMPTY) ||
                        (s1_in_range && s1_req_ff.last_neighbor);
   assign s1_advance  = s1_valid_ff && (!s1_emit || out_free);
   assign s1_wr       = s1_advance && (s1_req_ff.op == OP_CHUNK) && s1_in_range;
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_addr     = CHUNK_AW'(s1_req_ff.chunk_index);
   assign s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   shmr_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_CHUNKS)
   ) u_acc_ram (
      .clock      (clock),
      .wr_en      (s1_wr),
      .wr_addr    (s1_addr),
      .wr_data    (res_row),
      .rd_en      (accept),
      .rd_addr    (CHUNK_AW'(req_data.chunk_index)),
      .rd_data_ff (ram_rd)
   );

   // take the bypassed row when the RAM read raced the last write
   assign acc_row = (fw_valid_ff && (fw_addr_ff == s1_addr)) ? fw_data_ff : ram_rd;

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      shmr_lane u_lane (
         .first (s1_req_ff.first_neighbor),
         .acc   (acc_row[k*HALF_W +: HALF_W]),
         .x     (req_lane(s1_req_ff, k)),
         .res   (res_row[k*HALF_W +: HALF_W])
      );
   end

   // merge lane results into the response; unused lanes and empty segments read zero
   always_comb begin
      logic [HALF_W-1:0] m [4];
      for (int k = 0; k < 4; k++) begin
         m[k] = HALF_ZERO;
         if (k < LANES && s1_req_ff.op == OP_CHUNK) begin
            m[k] = res_row[k*HALF_W +: HALF_W];
         end
      end
      rsp_data_in.out_chunk = s1_req_ff.chunk_index;
      rsp_data_in.min_0     = m[0];
      rsp_data_in.min_1     = m[1];
      rsp_data_in.min_2     = m[2];
      rsp_data_in.min_3     = m[3];
      if (s1_advance && s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_wr) begin
            fw_valid_ff <= 1'b1;
         end
      end
      // hold the payload until it advances
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_wr) begin
         fw_addr_ff <= s1_addr;
         fw_data_ff <= res_row;
      end
      if (s1_advance && s1_emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction did not reach stage 1");

   a_s1_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("stalled stage 1 transaction changed");

   a_bypass_tracks_write: assert property (@(posedge clock) disable iff (reset)
      s1_wr |=> (fw_valid_ff && fw_addr_ff == $past(s1_addr)))
      else $error("bypass entry missed the last accumulator write");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_emit) |-> out_free)
      else $error("response overwritten before it was taken");
`endif

endmodule

>>> hdl/shmr_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module shmr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hdl/shmr_lane.sv
// One compare lane: picks the restart or running value and folds in the operand.
// Depends on shmr_pkg.
module shmr_lane
   import shmr_pkg::*;
(
   input  logic              first,
   input  logic [HALF_W-1:0] acc,
   input  logic [HALF_W-1:0] x,
   output logic [HALF_W-1:0] res
);

   logic [HALF_W-1:0] base;

   // restart the accumulator on a segment's first neighbor
   assign base = first ? HALF_MAX_FINITE : acc;
   assign res  = half_min(base, x);

endmodule

>>> bench/segmented_half_min_reduce_unit_tb.sv
// Testbench for the segmented half minimum reduction unit.
// Drives request transactions, predicts each response with its own half minimum
// accumulator copy and checks responses in order. Depends on shmr_pkg.
`timescale 1ns / 100ps

module segmented_half_min_reduce_unit_tb;
   import shmr_pkg::*;

   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Predictor state: one accumulator row per chunk, and which rows are written.
   logic [HALF_W-1:0] acc_row [MAX_CHUNKS][4];
   bit                row_live [MAX_CHUNKS];
   rsp_type           pending_mins [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int mismatches = 0;
   int responses_seen = 0;
   int items_sent = 0;
   int empty_sent = 0;

   segmented_half_min_reduce_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Strict-less half compare; NaN operand ignored, both zeros equal.
   function automatic logic [HALF_W-1:0] lesser_half(input logic [HALF_W-1:0] acc,
                                                    input logic [HALF_W-1:0] x);
      bit x_nan;
      bit a_nan;
      int kx;
      int ka;
      x_nan = (x[14:10] == 5'h1F) && (x[9:0] != 0);
      a_nan = (acc[14:10] == 5'h1F) && (acc[9:0] != 0);
      kx = x[15] ? -int'(x[14:0]) : int'(x[14:0]);
      ka = acc[15] ? -int'(acc[14:0]) : int'(acc[14:0]);
      if (x_nan) return acc;
      if (a_nan) return x;
      return (kx < ka) ? x : acc;
   endfunction

   // Fold one accepted transaction into the accumulators; queue any response.
   task automatic fold_min(input req_type r);
      logic [HALF_W-1:0] lanes [4];
      logic [HALF_W-1:0] res [4];
      rsp_type e;
      lanes = '{r.lane_0, r.lane_1, r.lane_2, r.lane_3};
      if (r.op == OP_EMPTY) begin
         e = '0;
         e.out_chunk = r.chunk_index;
         pending_mins.push_back(e);
         empty_sent++;
         return;
      end
      for (int k = 0; k < 4; k++) begin
         if (k < LANES) begin
            res[k] = lesser_half(r.first_neighbor ? HALF_MAX_FINITE
                                                  : acc_row[r.chunk_index][k], lanes[k]);
            acc_row[r.chunk_index][k] = res[k];
         end else begin
            res[k] = HALF_ZERO;
         end
      end
      row_live[r.chunk_index] = 1'b1;
      if (r.last_neighbor) begin
         e.out_chunk = r.chunk_index;
         e.min_0 = res[0];
         e.min_1 = res[1];
         e.min_2 = res[2];
         e.min_3 = res[3];
         pending_mins.push_back(e);
      end
   endtask

   // Offer one transaction, hold it until accepted, then predict.
   // Valid stays high into the next transaction unless the sender idles.
   task automatic send_item(input req_type r);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fold_min(r);
      items_sent++;
   endtask

   // Drop valid, wait for all predicted responses, then let the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_mins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [HALF_W-1:0] rand_half();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7C00;
         3: return 16'hFC00;
         4: return 16'h7C00 | 16'($urandom_range(1, 1023)) | (16'($urandom_range(1)) << 15);
         5: return 16'h7BFF;
         6: return 16'hFBFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_chunk(input int idx, input bit first, input bit last);
      req_type r;
      r.op = OP_CHUNK;
      r.chunk_index = 4'(idx);
      r.first_neighbor = first;
      r.last_neighbor = last;
      r.lane_0 = rand_half();
      r.lane_1 = rand_half();
      r.lane_2 = rand_half();
      r.lane_3 = rand_half();
      return r;
   endfunction

   // Send a full segment of n neighbors on one chunk position.
   task automatic send_segment(input int idx, input int n);
      for (int i = 0; i < n; i++)
         send_item(make_chunk(idx, i == 0, i == n - 1));
   endtask

   task automatic send_empty(input int idx);
      req_type r;
      r = make_chunk(idx, $urandom_range(1), $urandom_range(1));
      r.op = OP_EMPTY;
      send_item(r);
   endtask

   // Directed: lane extremes, zero signs, NaN and infinity, empty segment.
   task automatic test_directed();
      req_type r;
      r = '0;
      r.op = OP_CHUNK; r.first_neighbor = 1; r.last_neighbor = 1;
      r.lane_0 = 16'h0000; r.lane_1 = 16'hFFFF; r.lane_2 = 16'h7C01; r.lane_3 = 16'h7BFF;
      send_item(r);
      r.chunk_index = 4'hF; r.last_neighbor = 0;
      r.lane_0 = 16'h8000; r.lane_1 = 16'h7C00; r.lane_2 = 16'hFC00; r.lane_3 = 16'h0001;
      send_item(r);
      r.first_neighbor = 0;
      r.lane_0 = 16'h0000; r.lane_1 = 16'hFFFF; r.lane_2 = 16'h7FFF; r.lane_3 = 16'h8001;
      send_item(r);
      r.last_neighbor = 1;
      r.lane_0 = 16'hFBFF; r.lane_1 = 16'h3C00; r.lane_2 = 16'hBC00; r.lane_3 = 16'h8000;
      send_item(r);
      r.op = OP_EMPTY; r.chunk_index = 4'hA; r.lane_0 = 16'hFFFF;
      send_item(r);
      r.chunk_index = 4'h0; r.first_neighbor = 0; r.last_neighbor = 0;
      send_item(r);
      for (int i = 0; i < 16; i++) send_segment(i, 1 + (i % 3));
      wait_drained();
   endtask

   // Random segments, interleaving chunk positions and continuing live rows.
   task automatic test_random(input int count, input int idle, input int stall);
      int idx;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) begin
         idx = $urandom_range(MAX_CHUNKS - 1);
         case ($urandom_range(9))
            0: send_empty(idx);
            1, 2: begin
               if (row_live[idx]) send_item(make_chunk(idx, 0, $urandom_range(1)));
               else send_item(make_chunk(idx, 1, $urandom_range(1)));
            end
            default: send_segment(idx, $urandom_range(1, 5));
         endcase
      end
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering; then sender pauses.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 60;
      for (int i = 0; i < 30; i++) send_item(make_chunk(i % MAX_CHUNKS, 1, 1));
      wait_drained();
   endtask

   // Receiver: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending_mins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %h at %0t", rsp_data, $time);
         end else begin
            e = pending_mins.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: chunk %h/%h min %h %h %h %h / %h %h %h %h",
                           $time, e.out_chunk, rsp_data.out_chunk, e.min_0, e.min_1,
                           e.min_2, e.min_3, rsp_data.min_0, rsp_data.min_1,
                           rsp_data.min_2, rsp_data.min_3);
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(130, 0, 0);
      test_random(130, 49, 0);
      test_random(130, 0, 49);
      test_random(130, 24, 24);
      test_backpressure();
      test_random(50, 0, 0);
      wait_drained();
      if (pending_mins.size() != 0) mismatches += pending_mins.size();
      $display("Sent %0d transactions (%0d empty segments), checked %0d responses.",
               items_sent, empty_sent, responses_seen);
      $display("Covered all chunk positions, zero signs, NaN/infinity and backpressure.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
